// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on the rising edge of clock and are
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that, once seen, forces a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/psrmd_pkg.sv =====
package psrmd_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ROW_RD,
      ST_ROW_CAP,
      ST_ROW_RUN,
      ST_ROW_DRAIN,
      ST_ROW_WR,
      ST_SEL_RUN,
      ST_SEL_DRAIN,
      ST_REMOVE,
      ST_UPD_RUN,
      ST_UPD_DRAIN,
      ST_SEEK,
      ST_EMIT
   } state_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TARGET = 3'd0;

   localparam int TARGET_W = 11;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd1024;

   localparam int FIELD_W = 16;
   localparam int OUT_IDX_W = 10;

   // Read latency plus the two stages of the distance unit.
   localparam int DRAIN_CYC = 3;

endpackage

// ===== hdl/psrmd_ram.sv =====
module psrmd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/psrmd_sqdist.sv =====
module psrmd_sqdist #(
   parameter int CW = 16,
   parameter int TAG_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [TAG_W-1:0]    in_tag,
   input  logic [3*CW-1:0]     in_a,
   input  logic [3*CW-1:0]     in_b,
   output logic                out_valid,
   output logic [TAG_W-1:0]    out_tag,
   output logic [2*CW+3:0]     out_psum
);

   localparam int SQ_W = 2 * CW + 2;
   localparam int PS_W = 2 * CW + 4;

   logic [SQ_W-1:0]  sq_in [3];
   logic [SQ_W-1:0]  sq_ff [3];
   logic             s1_valid_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s2_valid_ff;
   logic [TAG_W-1:0] s2_tag_ff;
   logic [PS_W-1:0]  psum_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [CW:0] diff;
         diff = (CW+1)'($signed(in_a[k*CW +: CW])) - (CW+1)'($signed(in_b[k*CW +: CW]));
         sq_in[k] = SQ_W'(diff * diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      s1_tag_ff <= in_tag;
      s2_tag_ff <= s1_tag_ff;
      psum_ff <= PS_W'(sq_ff[0]) + PS_W'(sq_ff[1]) + PS_W'(sq_ff[2]);
   end

   assign out_valid = s2_valid_ff;
   assign out_tag = s2_tag_ff;
   assign out_psum = psum_ff;

endmodule

// ===== hdl/point_set_reduce_by_mean_distance.sv =====
// A load request is taken in every cycle while the block is idle; points of zero radius
// are skipped and points beyond MAX_POINTS are dropped and flagged. A load marked last
// starts the reduction, which runs through the single read port of the point, mark and sum
// memories at one entry per cycle: for each stored point, a pass that builds its distance
// sum, then for each point removed one scan for the smallest sum and one pass that
// subtracts the removed point's distances. A read request scans the alive marks from the
// read cursor, one entry per cycle, up to the next survivor after the returned one. No new
// request is taken while a reduction or a read scan runs; a finished result waits in the
// output register while loads go on.
`include "assert_macros.svh"

module point_set_reduce_by_mean_distance #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request: tdata = pos_x, pos_y, pos_z, radius; tuser = op; tlast = last_point.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,
   input  logic [0:0]                         req_tuser,
   input  logic                               req_tlast,
   // Result: tdata = point_index, out_x, out_y, out_z, zero fill; tuser = overflowed;
   // tlast = final_survivor.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [psrmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   import psrmd_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CRD_W = 3 * COORD_BITS;
   localparam int PS_W = 2 * COORD_BITS + 4;
   localparam int SUM_W = PS_W + IDX_W;
   localparam int TAG_W = IDX_W + SUM_W;
   localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

   state_type state_ff, state_in;

   logic [TARGET_W-1:0] target_ff;
   logic [CNT_W-1:0]    stored_ff;
   logic [CNT_W-1:0]    alive_n_ff;
   logic [CNT_W-1:0]    cursor_ff;
   logic                overflow_ff;
   logic [CNT_W-1:0]    ptr_ff;
   logic [IDX_W-1:0]    row_ff;
   logic [1:0]          drain_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [CRD_W-1:0]    ci_ff;
   logic [SUM_W-1:0]    acc_ff;
   logic                found_ff;
   logic                more_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [SUM_W-1:0]    best_sum_ff;
   logic [CRD_W-1:0]    best_crd_ff;

   logic                rsp_valid_ff;
   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic [FIELD_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                rsp_last_ff;
   logic                rsp_ovf_ff;

   logic [CRD_W-1:0]    crd_rdata;
   logic [0:0]          alv_rdata;
   logic [SUM_W-1:0]    sum_rdata;
   logic [IDX_W-1:0]    rd_addr;
   logic                crd_we;
   logic                alv_we;
   logic [IDX_W-1:0]    alv_waddr;
   logic [0:0]          alv_wdata;
   logic                sum_we;
   logic [IDX_W-1:0]    sum_waddr;
   logic [SUM_W-1:0]    sum_wdata;

   logic                sq_in_valid;
   logic [CRD_W-1:0]    sq_b;
   logic                sq_out_valid;
   logic [TAG_W-1:0]    sq_out_tag;
   logic [PS_W-1:0]     sq_out_psum;

   logic                req_fire;
   logic                req_op;
   logic [FIELD_W-1:0]  req_x, req_y, req_z, req_radius;
   logic                full;
   logic                load_store;
   logic                load_drop;
   logic                issue;
   logic                hit;
   logic                last_issue;
   logic                row_last;
   logic                row_mode;
   logic                upd_mode;
   logic                reduce_more;
   logic                reduce_after;
   logic                can_emit;
   logic                emit_fire;
   logic                clear_run;
   logic                drain_done;
   logic                csr_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign req_op = req_tuser[0];
   assign req_x = req_tdata[15:0];
   assign req_y = req_tdata[31:16];
   assign req_z = req_tdata[47:32];
   assign req_radius = req_tdata[63:48];

   assign full = (stored_ff == CNT_W'(MAX_POINTS));
   assign load_store = req_fire && (req_op == OP_LOAD) && (req_radius != '0) && !full;
   assign load_drop = req_fire && (req_op == OP_LOAD) && (req_radius != '0) && full;

   assign hit = rd_vld_ff && alv_rdata[0];
   assign last_issue = (ptr_ff == CNT_W'(stored_ff - 1'b1));
   assign row_last = (CNT_W'(row_ff) == CNT_W'(stored_ff - 1'b1));
   assign row_mode = (state_ff == ST_ROW_RUN) || (state_ff == ST_ROW_DRAIN);
   assign upd_mode = (state_ff == ST_UPD_RUN) || (state_ff == ST_UPD_DRAIN);
   assign reduce_more = CMP_W'(alive_n_ff) > CMP_W'(target_ff);
   assign reduce_after = CMP_W'(CNT_W'(alive_n_ff - 1'b1)) > CMP_W'(target_ff);
   assign can_emit = !rsp_valid_ff || rsp_tready;
   assign emit_fire = (state_ff == ST_EMIT) && can_emit;
   assign clear_run = emit_fire && !more_ff;
   assign drain_done = (drain_ff == 2'(DRAIN_CYC - 1));

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_TARGET) ? 32'(target_ff) : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_READ) begin
                  state_in = ST_SEEK;
               end else if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK:     state_in = reduce_more ? ST_ROW_RD : ST_IDLE;
         ST_ROW_RD:    state_in = ST_ROW_CAP;
         ST_ROW_CAP: begin
            if (alv_rdata[0]) begin
               state_in = ST_ROW_RUN;
            end else begin
               state_in = row_last ? ST_SEL_RUN : ST_ROW_RD;
            end
         end
         ST_ROW_RUN:   state_in = last_issue ? ST_ROW_DRAIN : ST_ROW_RUN;
         ST_ROW_DRAIN: state_in = drain_done ? ST_ROW_WR : ST_ROW_DRAIN;
         ST_ROW_WR:    state_in = row_last ? ST_SEL_RUN : ST_ROW_RD;
         ST_SEL_RUN:   state_in = last_issue ? ST_SEL_DRAIN : ST_SEL_RUN;
         ST_SEL_DRAIN: state_in = ST_REMOVE;
         ST_REMOVE:    state_in = reduce_after ? ST_UPD_RUN : ST_IDLE;
         ST_UPD_RUN:   state_in = last_issue ? ST_UPD_DRAIN : ST_UPD_RUN;
         ST_UPD_DRAIN: state_in = drain_done ? ST_SEL_RUN : ST_UPD_DRAIN;
         ST_SEEK: begin
            if (hit && found_ff) begin
               state_in = ST_EMIT;
            end else if ((ptr_ff >= stored_ff) && !rd_vld_ff) begin
               state_in = found_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT:      state_in = can_emit ? ST_IDLE : ST_EMIT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Memory ports and the distance unit's inputs.
   always_comb begin
      issue = 1'b0;
      rd_addr = ptr_ff[IDX_W-1:0];
      crd_we = load_store;
      alv_we = 1'b0;
      alv_waddr = stored_ff[IDX_W-1:0];
      alv_wdata = 1'b1;
      sum_we = 1'b0;
      sum_waddr = row_ff;
      sum_wdata = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            alv_we = load_store;
         end
         ST_ROW_RD: begin
            rd_addr = row_ff;
         end
         ST_ROW_RUN, ST_SEL_RUN, ST_UPD_RUN: begin
            issue = 1'b1;
         end
         ST_ROW_WR: begin
            sum_we = 1'b1;
         end
         ST_REMOVE: begin
            alv_we = 1'b1;
            alv_waddr = best_idx_ff;
            alv_wdata = 1'b0;
         end
         ST_SEEK: begin
            issue = (ptr_ff < stored_ff) && !(hit && found_ff);
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      if (upd_mode && sq_out_valid) begin
         sum_we = 1'b1;
         sum_waddr = sq_out_tag[TAG_W-1 -: IDX_W];
         sum_wdata = sq_out_tag[SUM_W-1:0] - SUM_W'(sq_out_psum);
      end
   end

   assign sq_in_valid = hit && ((row_mode && (rd_idx_ff != row_ff)) || upd_mode);
   assign sq_b = row_mode ? ci_ff : best_crd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         target_ff <= TARGET_RESET;
         stored_ff <= '0;
         alive_n_ff <= '0;
         cursor_ff <= '0;
         overflow_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         more_ff <= 1'b0;
         drain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= issue;

         if (csr_wr && (csr_paddr == ADDR_TARGET)) begin
            target_ff <= csr_pwdata[TARGET_W-1:0];
         end

         if (clear_run) begin
            stored_ff <= '0;
            alive_n_ff <= '0;
            cursor_ff <= '0;
            overflow_ff <= 1'b0;
         end else begin
            if (load_store) begin
               stored_ff <= stored_ff + 1'b1;
               alive_n_ff <= alive_n_ff + 1'b1;
            end else if (state_ff == ST_REMOVE) begin
               alive_n_ff <= alive_n_ff - 1'b1;
            end
            if (load_drop) begin
               overflow_ff <= 1'b1;
            end
            if (emit_fire) begin
               cursor_ff <= CNT_W'(best_idx_ff) + 1'b1;
            end
         end

         drain_ff <= (state_ff == ST_ROW_DRAIN || state_ff == ST_UPD_DRAIN) ?
                     drain_ff + 1'b1 : '0;

         if (state_in != state_ff && (state_in == ST_SEL_RUN || state_in == ST_SEEK)) begin
            found_ff <= 1'b0;
            more_ff <= 1'b0;
         end else if (hit && (state_ff == ST_SEL_RUN || state_ff == ST_SEL_DRAIN)) begin
            if (!found_ff || (sum_rdata <= best_sum_ff)) begin
               found_ff <= 1'b1;
            end
         end else if (hit && state_ff == ST_SEEK) begin
            if (found_ff) begin
               more_ff <= 1'b1;
            end else begin
               found_ff <= 1'b1;
            end
         end

         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (state_in != state_ff) begin
         if (state_in == ST_SEEK) begin
            ptr_ff <= cursor_ff;
         end else begin
            ptr_ff <= '0;
         end
      end else if (issue) begin
         ptr_ff <= ptr_ff + 1'b1;
      end

      if (issue) begin
         rd_idx_ff <= ptr_ff[IDX_W-1:0];
      end

      if (state_ff == ST_CHECK) begin
         row_ff <= '0;
      end else if ((state_ff == ST_ROW_CAP && !alv_rdata[0]) || state_ff == ST_ROW_WR) begin
         row_ff <= row_ff + 1'b1;
      end

      if (state_ff == ST_ROW_CAP) begin
         ci_ff <= crd_rdata;
         acc_ff <= '0;
      end else if (row_mode && sq_out_valid) begin
         acc_ff <= acc_ff + SUM_W'(sq_out_psum);
      end

      if (hit && (state_ff == ST_SEL_RUN || state_ff == ST_SEL_DRAIN)) begin
         // Ties go to the later entry, so the newest of equal sums is removed.
         if (!found_ff || (sum_rdata <= best_sum_ff)) begin
            best_idx_ff <= rd_idx_ff;
            best_sum_ff <= sum_rdata;
            best_crd_ff <= crd_rdata;
         end
      end else if (hit && state_ff == ST_SEEK && !found_ff) begin
         best_idx_ff <= rd_idx_ff;
         best_crd_ff <= crd_rdata;
      end

      if (emit_fire) begin
         rsp_idx_ff <= OUT_IDX_W'(best_idx_ff);
         rsp_x_ff <= FIELD_W'($signed(best_crd_ff[COORD_BITS-1:0]));
         rsp_y_ff <= FIELD_W'($signed(best_crd_ff[2*COORD_BITS-1:COORD_BITS]));
         rsp_z_ff <= FIELD_W'($signed(best_crd_ff[3*COORD_BITS-1:2*COORD_BITS]));
         rsp_last_ff <= !more_ff;
         rsp_ovf_ff <= overflow_ff;
      end
   end

   psrmd_ram #(
      .DATA_W (CRD_W),
      .DEPTH  (MAX_POINTS)
   ) u_coord_ram (
      .clock   (clock),
      .wr_en   (crd_we),
      .wr_addr (stored_ff[IDX_W-1:0]),
      .wr_data ({COORD_BITS'(req_z), COORD_BITS'(req_y), COORD_BITS'(req_x)}),
      .rd_addr (rd_addr),
      .rd_data (crd_rdata)
   );

   psrmd_ram #(
      .DATA_W (1),
      .DEPTH  (MAX_POINTS)
   ) u_alive_ram (
      .clock   (clock),
      .wr_en   (alv_we),
      .wr_addr (alv_waddr),
      .wr_data (alv_wdata),
      .rd_addr (rd_addr),
      .rd_data (alv_rdata)
   );

   psrmd_ram #(
      .DATA_W (SUM_W),
      .DEPTH  (MAX_POINTS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (rd_addr),
      .rd_data (sum_rdata)
   );

   psrmd_sqdist #(
      .CW    (COORD_BITS),
      .TAG_W (TAG_W)
   ) u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_in_valid),
      .in_tag    ({rd_idx_ff, sum_rdata}),
      .in_a      (crd_rdata),
      .in_b      (sq_b),
      .out_valid (sq_out_valid),
      .out_tag   (sq_out_tag),
      .out_psum  (sq_out_psum)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'b0, rsp_z_ff, rsp_y_ff, rsp_x_ff, rsp_idx_ff};
   assign rsp_tuser = rsp_ovf_ff;
   assign rsp_tlast = rsp_last_ff;

   `ASSERT_ALWAYS(a_alive_le_stored, alive_n_ff <= stored_ff, "more alive points than stored")
   `ASSERT_ALWAYS(a_stored_le_max, stored_ff <= CNT_W'(MAX_POINTS), "store count past capacity")
   `ASSERT_IMPLY(a_remove_found, state_ff == ST_REMOVE, found_ff, "removal without a candidate")
   `ASSERT_IMPLY(a_emit_found, state_ff == ST_EMIT, found_ff, "result without a survivor")
   `ASSERT_IMPLY(a_sq_mode, sq_out_valid, row_mode || upd_mode, "distance result outside a pass")

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import psrmd_pkg::*;

   localparam int CAPACITY  = 1024;
   localparam int STALL_MAX = 10000000;

   typedef struct {
      bit [9:0]  idx;
      bit [15:0] x;
      bit [15:0] y;
      bit [15:0] z;
      bit        fin;
      bit        ovf;
   } survivor_type;

   // Keeps its own copy of the point store and predicts every survivor read.
   class reduce_scoreboard_type;
      bit [15:0]       px[CAPACITY];
      bit [15:0]       py[CAPACITY];
      bit [15:0]       pz[CAPACITY];
      bit              alive[CAPACITY];
      longint unsigned dsum[CAPACITY];
      int              stored;
      int              cursor;
      bit              ovf;
      int              target = 1024;
      survivor_type    pending[$];
      int              errors;
      int              results;
      int              removed;

      function longint unsigned sq_dist(int a, int b);
         longint d0, d1, d2;
         d0 = longint'($signed(px[a])) - longint'($signed(px[b]));
         d1 = longint'($signed(py[a])) - longint'($signed(py[b]));
         d2 = longint'($signed(pz[a])) - longint'($signed(pz[b]));
         return d0 * d0 + d1 * d1 + d2 * d2;
      endfunction

      function void clear_run();
         foreach (alive[i]) alive[i] = 0;
         stored = 0;
         cursor = 0;
         ovf = 0;
      endfunction

      function void thin_out();
         int n, victim;
         bit found;
         n = 0;
         for (int i = 0; i < stored; i++) if (alive[i]) n++;
         if (n <= target) return;
         for (int i = 0; i < stored; i++) begin
            if (!alive[i]) continue;
            dsum[i] = 0;
            for (int j = 0; j < stored; j++)
               if (j != i && alive[j]) dsum[i] += sq_dist(i, j);
         end
         while (n > target) begin
            found = 0;
            victim = 0;
            // Ties go to the latest-loaded point, hence the less-or-equal.
            for (int i = 0; i < stored; i++)
               if (alive[i] && (!found || dsum[i] <= dsum[victim])) begin
                  victim = i;
                  found = 1;
               end
            if (!found) break;
            alive[victim] = 0;
            n--;
            removed++;
            for (int i = 0; i < stored; i++)
               if (alive[i]) dsum[i] -= sq_dist(i, victim);
         end
      endfunction

      function void note_request(bit op, bit [15:0] x, bit [15:0] y, bit [15:0] z,
                                 bit [15:0] r, bit last);
         int i, nxt;
         survivor_type s;
         if (op == OP_LOAD) begin
            if (r != 0) begin
               if (stored >= CAPACITY) ovf = 1;
               else begin
                  px[stored] = x;
                  py[stored] = y;
                  pz[stored] = z;
                  alive[stored] = 1;
                  stored++;
               end
            end
            if (last) thin_out();
            return;
         end
         i = cursor;
         while (i < stored && !alive[i]) i++;
         if (i >= stored) return;
         nxt = i + 1;
         while (nxt < stored && !alive[nxt]) nxt++;
         s.idx = i[9:0];
         s.x = px[i];
         s.y = py[i];
         s.z = pz[i];
         s.fin = (nxt >= stored);
         s.ovf = ovf;
         pending.insert(pending.size(), s);
         cursor = i + 1;
         if (s.fin) clear_run();
      endfunction

      function void check(bit [63:0] data, bit ovf_bit, bit fin_bit);
         survivor_type s;
         results++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected survivor: data=%h", data);
            return;
         end
         s = pending.pop_front();
         if (data[9:0] != s.idx || data[25:10] != s.x || data[41:26] != s.y ||
             data[57:42] != s.z || data[63:58] != 0 || fin_bit != s.fin ||
             ovf_bit != s.ovf) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp idx=%0d x=%h y=%h z=%h last=%b ovf=%b, ",
                         "got idx=%0d x=%h y=%h z=%h last=%b ovf=%b fill=%h"},
                        s.idx, s.x, s.y, s.z, s.fin, s.ovf, data[9:0], data[25:10],
                        data[41:26], data[57:42], fin_bit, ovf_bit, data[63:58]);
         end
      endfunction

      function int alive_total();
         int n;
         n = 0;
         for (int i = 0; i < stored; i++) if (alive[i]) n++;
         return n;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   reduce_scoreboard_type sb = new();
   int  sent;
   int  runs;
   bit  steady_rx;
   int  quiet_cycles;

   point_set_reduce_by_mean_distance dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Random backpressure on the result side, with stretches of none at all.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if ($urandom_range(0, 199) == 0) steady_rx <= ~steady_rx;
      else rsp_tready <= steady_rx ? 1'b1 : ($urandom_range(0, 9) < 6 ||
                                             ($urandom_range(0, 20) == 0 ? 0 : rsp_tready));
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check(rsp_tdata, rsp_tuser[0], rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("watchdog: no progress for %0d cycles", STALL_MAX);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Leaves req_tvalid high when the next request follows without a gap.
   task automatic send(bit op, bit [15:0] x, bit [15:0] y, bit [15:0] z, bit [15:0] r,
                       bit last, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tlast <= last;
      req_tdata <= {r, z, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, x, y, z, r, last);
      sent++;
   endtask

   task automatic load(bit [15:0] x, bit [15:0] y, bit [15:0] z, bit [15:0] r, bit last);
      send(OP_LOAD, x, y, z, r, last);
   endtask

   task automatic read_one();
      send(OP_READ, 16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
           1'($urandom_range(0, 1)));
   endtask

   task automatic drain_run();
      while (sb.stored != 0) read_one();
   endtask

   // The reduction produces no result, so also wait for the block to take requests again.
   task automatic wait_idle();
      int ready_run;
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      ready_run = 0;
      while (ready_run < 4) begin
         @(posedge clock);
         ready_run = req_tready ? ready_run + 1 : 0;
      end
   endtask

   task automatic write_target(int value);
      wait_idle();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_TARGET;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      sb.target = value;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic random_run();
      int k, spread;
      bit [15:0] bx, by, bz, r;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      spread = $urandom_range(0, 2);
      bx = 16'($urandom());
      by = 16'($urandom());
      bz = 16'($urandom());
      for (int i = 0; i < k; i++) begin
         r = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
         if (spread == 0)
            load(16'($urandom()), 16'($urandom()), 16'($urandom()), r, i == k - 1);
         else load(16'(bx + $urandom_range(0, 3)), 16'(by + $urandom_range(0, 3)),
                   16'(bz + $urandom_range(0, 3)), r, i == k - 1);
         if (i < k - 1 && $urandom_range(0, 19) == 0) read_one();
      end
      // Now and then a few points arrive while survivors are being read out.
      while (sb.stored != 0) begin
         read_one();
         if ($urandom_range(0, 29) == 0)
            load(16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom_range(1, 65535)), 0);
      end
      if ($urandom_range(0, 9) == 0) read_one();
      runs++;
   endtask

   initial begin
      reset = 1;
      steady_rx = 0;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      req_tlast = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Extremes, a zero-radius last load and a read ahead of the last load.
      write_target(2);
      load(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
      load(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 0);
      read_one();
      load(16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 0);
      load(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 1);
      drain_run();
      read_one();

      // Identical points tie on every sum; the latest ones must go first.
      write_target(1);
      for (int i = 0; i < 4; i++) load(16'h0101, 16'hFEFE, 16'h4000, 16'h0010, i == 3);
      read_one();
      load(16'hFFFF, 16'h0001, 16'h7FFF, 16'h00FF, 0);
      load(16'h0001, 16'hFFFF, 16'h8000, 16'hFF00, 1);
      drain_run();

      // Fill the store past capacity, then reduce the full store to a few hundred points.
      write_target(300);
      for (int i = 0; i <= CAPACITY; i++)
         load(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom_range(1, 65535)), i == CAPACITY);
      drain_run();

      while (sent < 1650) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: write_target(1);
               1: write_target(1024);
               default: write_target($urandom_range(1, 30));
            endcase
         end
         random_run();
      end

      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d requests in %0d random runs plus directed cases and an overflow run;",
               sent, runs);
      $display("%0d survivors checked, %0d points removed by reduction.", sb.results, sb.removed);
      if (sb.errors == 0) $display("RESULT: OK");
      else begin
         $display("%0d mismatches", sb.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
